// ===== rtl/cp0rb_pkg.sv =====
// Shared types, register addresses and constants of the coprocessor-0 register bank.
`timescale 1ns / 1ps
`default_nettype none
package cp0rb_pkg;

  localparam logic ActRead  = 1'b0;
  localparam logic ActWrite = 1'b1;

  localparam logic [4:0] RegUserLocal = 5'd4;
  localparam logic [4:0] RegStatus    = 5'd12;
  localparam logic [4:0] RegEpc       = 5'd14;
  localparam logic [4:0] RegEbase     = 5'd15;
  localparam logic [4:0] RegConfig    = 5'd16;
  localparam logic [4:0] RegErrorEpc  = 5'd30;
  localparam logic [4:0] RegScratch   = 5'd31;

  localparam logic [2:0] SelUserLocal = 3'd2;
  localparam logic [2:0] SelStatus    = 3'd0;
  localparam logic [2:0] SelIntCtl    = 3'd1;
  localparam logic [2:0] SelEpc       = 3'd0;
  localparam logic [2:0] SelEbase     = 3'd1;
  localparam logic [2:0] SelErrorEpc  = 3'd0;
  localparam logic [2:0] SelScratchLo = 3'd2;

  localparam int unsigned ScratchCount = 6;

  localparam logic [31:0] StatusReset = 32'h2440_0004;
  localparam logic [31:0] StatusWmask = 32'h1000_FF13;
  localparam logic [31:0] IntCtlValue = 32'hC000_0000;
  localparam logic [31:0] EbaseReset  = 32'h8000_0000;
  localparam logic [31:0] EbaseWmask  = 32'hFFFF_F000;
  localparam logic [31:0] EbaseTop    = 32'hC000_0000;
  localparam logic [31:0] EbaseGate   = 32'h0000_0800;

  // one accepted command beat
  typedef struct packed {
    logic        valid;
    logic        action;
    logic [4:0]  reg_num;
    logic [2:0]  sel;
    logic [31:0] wr_data;
  } cmd_t;

  // Config0..Config4; selects 5..7 read as zero
  function automatic logic [31:0] config_word(input logic [2:0] sel);
    logic [31:0] w;
    case (sel)
      3'd0:    w = 32'h0000_0400;
      3'd1:    w = 32'h8000_0001;
      3'd2:    w = 32'h8000_0000;
      3'd3:    w = 32'h8C00_2000;
      3'd4:    w = 32'h00FF_0000;
      default: w = 32'h0000_0000;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cp0rb_cmd_reg.sv =====
// Input command register of the coprocessor-0 register bank.
`timescale 1ns / 1ps
`default_nettype none
module cp0rb_cmd_reg
  import cp0rb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        take_i,
  input  wire logic        action_i,
  input  wire logic [4:0]  reg_num_i,
  input  wire logic [2:0]  select_i,
  input  wire logic [31:0] wr_data_i,
  output cmd_t             cmd_o
);

  logic        valid_q;
  logic        action_q;
  logic [4:0]  reg_num_q;
  logic [2:0]  sel_q;
  logic [31:0] wr_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      action_q  <= action_i;
      reg_num_q <= reg_num_i;
      sel_q     <= select_i;
      wr_data_q <= wr_data_i;
    end
  end

  assign cmd_o = '{valid: valid_q, action: action_q, reg_num: reg_num_q,
                   sel: sel_q, wr_data: wr_data_q};

endmodule
`default_nettype wire

// ===== rtl/cp0rb_regs.sv =====
// Register storage, write decode and registered read mux of the coprocessor-0 bank.
`timescale 1ns / 1ps
`default_nettype none
module cp0rb_regs
  import cp0rb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  cmd_t             cmd_i,
  output logic             rd_valid_o,
  output logic [31:0]      rd_data_o
);

  logic [31:0] status_q, epc_q, error_epc_q, user_local_q, ebase_q;
  logic [31:0] scratch_q [ScratchCount];
  logic [31:0] ebase_mask;
  logic [31:0] rd_data_d, rd_data_q;
  logic        rd_valid_q;
  logic        wr_en;
  logic        scratch_sel;
  logic [2:0]  scratch_idx;

  assign wr_en       = cmd_i.valid && (cmd_i.action == ActWrite);
  assign scratch_sel = cmd_i.sel inside {[SelScratchLo:3'd7]};
  assign scratch_idx = cmd_i.sel - SelScratchLo;

  // with the write gate clear, the top two bits are held
  assign ebase_mask = ((ebase_q & EbaseGate) != '0) ? EbaseWmask : (EbaseWmask & ~EbaseTop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q     <= StatusReset;
      epc_q        <= '0;
      error_epc_q  <= '0;
      user_local_q <= '0;
      ebase_q      <= EbaseReset;
      for (int i = 0; i < ScratchCount; i++) begin
        scratch_q[i] <= '0;
      end
    end else if (wr_en) begin
      case (cmd_i.reg_num)
        RegUserLocal: begin
          if (cmd_i.sel == SelUserLocal) user_local_q <= cmd_i.wr_data;
        end
        RegStatus: begin
          if (cmd_i.sel == SelStatus) begin
            status_q <= (status_q & ~StatusWmask) | (cmd_i.wr_data & StatusWmask);
          end
        end
        RegEpc: begin
          if (cmd_i.sel == SelEpc) epc_q <= cmd_i.wr_data;
        end
        RegEbase: begin
          if (cmd_i.sel == SelEbase) begin
            ebase_q <= (ebase_q & ~ebase_mask) | (cmd_i.wr_data & ebase_mask);
          end
        end
        RegErrorEpc: begin
          if (cmd_i.sel == SelErrorEpc) error_epc_q <= cmd_i.wr_data;
        end
        RegScratch: begin
          if (scratch_sel) scratch_q[scratch_idx] <= cmd_i.wr_data;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_data_d = '0;
    case (cmd_i.reg_num)
      RegUserLocal: if (cmd_i.sel == SelUserLocal) rd_data_d = user_local_q;
      RegStatus: begin
        if (cmd_i.sel == SelStatus)      rd_data_d = status_q;
        else if (cmd_i.sel == SelIntCtl) rd_data_d = IntCtlValue;
      end
      RegEpc:      if (cmd_i.sel == SelEpc)      rd_data_d = epc_q;
      RegEbase:    if (cmd_i.sel == SelEbase)    rd_data_d = ebase_q;
      RegConfig:   rd_data_d = config_word(cmd_i.sel);
      RegErrorEpc: if (cmd_i.sel == SelErrorEpc) rd_data_d = error_epc_q;
      RegScratch:  if (scratch_sel)              rd_data_d = scratch_q[scratch_idx];
      default:     rd_data_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.valid && (cmd_i.action == ActRead);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= rd_data_d;
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_data_o  = rd_data_q;

endmodule
`default_nettype wire

// ===== rtl/cp0_register_bank.sv =====
// Top level of the coprocessor-0 system register bank.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   A command beat (action_i, reg_num_i, select_i, wr_data_i) is taken at a
//   rising edge with start_i high and busy_o low. busy_o is always low, so a
//   command can be issued every cycle: one beat per cycle sustained.
//   A write updates the addressed register and returns nothing. A read
//   returns one beat: rd_valid_o is high for exactly one cycle with
//   rd_data_o, registered first in the command register and then in the
//   result register. Unimplemented addresses read as zero; IntCtl and
//   Config0..Config4 are read-only and return their constant values.
//   Commands take effect in issue order, so a read right after a write to
//   the same register sees the new value.
//   Reset (rst_ni low, asynchronous) drops any command in flight and loads
//   Status with 0x24400004, EBase with 0x80000000 and clears the rest.
//   The receiver cannot stall; each result beat is offered once only.
module cp0_register_bank
  import cp0rb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        action_i,
  input  wire logic [4:0]  reg_num_i,
  input  wire logic [2:0]  select_i,
  input  wire logic [31:0] wr_data_i,
  output logic             rd_valid_o,
  output logic [31:0]      rd_data_o
);

  cmd_t cmd;

  assign busy_o = 1'b0;

  cp0rb_cmd_reg u_cmd_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (start_i && !busy_o),
    .action_i  (action_i),
    .reg_num_i (reg_num_i),
    .select_i  (select_i),
    .wr_data_i (wr_data_i),
    .cmd_o     (cmd)
  );

  cp0rb_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rd_valid_o (rd_valid_o),
    .rd_data_o  (rd_data_o)
  );

endmodule
`default_nettype wire

// ===== verif/cp0_register_bank_tb.sv =====
// Self-checking testbench of the coprocessor-0 register bank: directed and random reads/writes.
`timescale 1ns / 1ps
module cp0_register_bank_tb;
  import cp0rb_pkg::*;

  // read-only and unimplemented addresses, not in the package
  localparam logic [4:0] RegNone     = 5'd0;
  localparam logic [4:0] RegHwrEna   = 5'd7;
  localparam logic [4:0] RegBadAddr  = 5'd8;
  localparam logic [4:0] RegCause    = 5'd13;
  localparam logic [4:0] RegPrId     = 5'd15;
  localparam logic [2:0] SelZero     = 3'd0;
  localparam logic [2:0] SelBadInstr = 3'd1;
  localparam logic [2:0] SelSrsCtl   = 3'd2;
  localparam logic [2:0] SelTop      = 3'd7;

  localparam int unsigned CfgCount = 5;
  localparam logic [CfgCount-1:0][31:0] CfgWords = {
    32'h00FF_0000, 32'h8C00_2000, 32'h8000_0000, 32'h8000_0001, 32'h0000_0400
  };

  localparam int unsigned PhaseItems = 200;
  localparam int unsigned CycleLimit = 200000;

  // shadow of the writable registers; queues the expected read data
  class cp0_readback_tracker;
    logic [31:0] status_r, epc_r, error_epc_r, user_local_r, ebase_r;
    logic [31:0] scratch_r [ScratchCount];
    logic [31:0] pending_reads [$];
    int unsigned mismatches;
    int unsigned reads_checked;

    function new();
      status_r     = StatusReset;
      epc_r        = '0;
      error_epc_r  = '0;
      user_local_r = '0;
      ebase_r      = EbaseReset;
      foreach (scratch_r[i]) scratch_r[i] = '0;
      mismatches    = 0;
      reads_checked = 0;
    endfunction

    function logic [31:0] lookup(logic [4:0] num, logic [2:0] sel);
      logic [31:0] v;
      v = '0;
      case (num)
        RegUserLocal: if (sel == SelUserLocal) v = user_local_r;
        RegStatus: begin
          if (sel == SelStatus) v = status_r;
          else if (sel == SelIntCtl) v = IntCtlValue;
        end
        RegEpc:      if (sel == SelEpc) v = epc_r;
        RegEbase:    if (sel == SelEbase) v = ebase_r;
        RegConfig:   if (sel < CfgCount) v = CfgWords[sel];
        RegErrorEpc: if (sel == SelErrorEpc) v = error_epc_r;
        RegScratch:  if (sel >= SelScratchLo) v = scratch_r[sel - SelScratchLo];
        default: ;
      endcase
      return v;
    endfunction

    function void note_command(logic act, logic [4:0] num, logic [2:0] sel,
                               logic [31:0] data);
      logic [31:0] m;
      if (act == ActRead) begin
        pending_reads.push_back(lookup(num, sel));
      end else begin
        if (num == RegUserLocal && sel == SelUserLocal) begin
          user_local_r = data;
        end else if (num == RegStatus && sel == SelStatus) begin
          status_r = (status_r & ~StatusWmask) | (data & StatusWmask);
        end else if (num == RegEpc && sel == SelEpc) begin
          epc_r = data;
        end else if (num == RegEbase && sel == SelEbase) begin
          // top two bits are frozen while the write gate is clear
          m = EbaseWmask;
          if ((ebase_r & EbaseGate) == '0) m = m & ~EbaseTop;
          ebase_r = (ebase_r & ~m) | (data & m);
        end else if (num == RegErrorEpc && sel == SelErrorEpc) begin
          error_epc_r = data;
        end else if (num == RegScratch && sel >= SelScratchLo) begin
          scratch_r[sel - SelScratchLo] = data;
        end
      end
    endfunction

    function void check_read(logic [31:0] got);
      logic [31:0] want;
      if (pending_reads.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected read beat, expected none, actual 0x%08h", $time, got);
      end else begin
        want = pending_reads.pop_front();
        reads_checked++;
        if (got !== want) begin
          mismatches++;
          $display("%0t: rd_data expected 0x%08h actual 0x%08h", $time, want, got);
        end
      end
    endfunction
  endclass

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        start_i    = 1'b0;
  logic        action_i   = 1'b0;
  logic [4:0]  reg_num_i  = '0;
  logic [2:0]  select_i   = '0;
  logic [31:0] wr_data_i  = '0;
  logic        busy_o;
  logic        rd_valid_o;
  logic [31:0] rd_data_o;

  cp0_readback_tracker bank;
  int unsigned idle_pct;
  int unsigned cmds_sent;
  int unsigned cycle_count = 0;

  cp0_register_bank u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .action_i   (action_i),
    .reg_num_i  (reg_num_i),
    .select_i   (select_i),
    .wr_data_i  (wr_data_i),
    .rd_valid_o (rd_valid_o),
    .rd_data_o  (rd_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout, %0d reads still pending", $time, bank.pending_reads.size());
      $display("simulation failed");
      $finish;
    end
  end

  // values read here are the ones from before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && busy_o === 1'b0)
        bank.note_command(action_i, reg_num_i, select_i, wr_data_i);
      if (rd_valid_o !== 1'b0)
        bank.check_read(rd_data_o);
    end
  end

  task automatic issue(input logic act, input logic [4:0] num, input logic [2:0] sel,
                       input logic [31:0] data);
    while ($urandom_range(99) < idle_pct) begin
      start_i   <= 1'b0;
      action_i  <= 1'($urandom);
      reg_num_i <= 5'($urandom);
      select_i  <= 3'($urandom);
      wr_data_i <= $urandom;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    action_i  <= act;
    reg_num_i <= num;
    select_i  <= sel;
    wr_data_i <= data;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    cmds_sent++;
  endtask

  function automatic logic [31:0] pick_data();
    logic [31:0] one_hot;
    one_hot = 32'h1 << $urandom_range(31);
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      default: return $urandom;
    endcase
  endfunction

  // mostly implemented registers, with read-only and random addresses mixed in
  task automatic pick_addr(output logic [4:0] num, output logic [2:0] sel);
    case ($urandom_range(11))
      0: begin num = RegUserLocal; sel = SelUserLocal; end
      1: begin num = RegStatus;    sel = SelStatus;    end
      2: begin num = RegStatus;    sel = SelIntCtl;    end
      3: begin num = RegEpc;       sel = SelEpc;       end
      4: begin num = RegEbase;     sel = SelEbase;     end
      5: begin num = RegConfig;    sel = 3'($urandom); end
      6: begin num = RegErrorEpc;  sel = SelErrorEpc;  end
      7: begin num = RegScratch;   sel = 3'($urandom); end
      8: begin
        case ($urandom_range(5))
          0: begin num = RegHwrEna;  sel = SelZero;     end
          1: begin num = RegBadAddr; sel = SelZero;     end
          2: begin num = RegBadAddr; sel = SelBadInstr; end
          3: begin num = RegStatus;  sel = SelSrsCtl;   end
          4: begin num = RegCause;   sel = SelZero;     end
          default: begin num = RegPrId; sel = SelZero; end
        endcase
      end
      default: begin num = 5'($urandom); sel = 3'($urandom); end
    endcase
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned n;
    logic [4:0]  num;
    logic [2:0]  sel;
    n = 0;
    while (n < count) begin
      pick_addr(num, sel);
      if ($urandom_range(99) < 40) begin
        // write then read back the same register
        issue(ActWrite, num, sel, pick_data());
        issue(ActRead, num, sel, $urandom);
        n += 2;
      end else begin
        issue(1'($urandom), num, sel, pick_data());
        n++;
      end
    end
  endtask

  initial begin
    bank = new();
    cmds_sent = 0;
    idle_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values and constants, Config selects past the last one read zero
    issue(ActRead, RegStatus, SelStatus, '0);
    issue(ActRead, RegStatus, SelIntCtl, '0);
    issue(ActRead, RegEbase, SelEbase, '0);
    for (int s = 0; s <= CfgCount; s++) issue(ActRead, RegConfig, 3'(s), '0);
    issue(ActRead, RegNone, SelZero, '1);
    issue(ActWrite, RegStatus, SelStatus, '1);
    issue(ActRead, RegStatus, SelStatus, '0);
    // EBase top bits must hold with the gate clear
    issue(ActWrite, RegEbase, SelEbase, '1);
    issue(ActRead, RegEbase, SelEbase, '0);
    issue(ActWrite, RegEbase, SelEbase, '0);
    issue(ActRead, RegEbase, SelEbase, '0);
    issue(ActWrite, RegEpc, SelEpc, '1);
    issue(ActWrite, RegErrorEpc, SelErrorEpc, 32'hA5A5_5A5A);
    issue(ActWrite, RegUserLocal, SelUserLocal, 32'h5A5A_A5A5);
    issue(ActWrite, RegScratch, SelTop, '1);
    issue(ActWrite, RegScratch, SelBadInstr, '1);
    issue(ActWrite, RegCause, SelZero, '1);
    issue(ActRead, RegEpc, SelEpc, '0);
    issue(ActRead, RegErrorEpc, SelErrorEpc, '0);
    issue(ActRead, RegUserLocal, SelUserLocal, '0);
    issue(ActRead, RegScratch, SelTop, '0);
    issue(ActRead, RegScratch, SelBadInstr, '0);
    issue(ActRead, RegCause, SelZero, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       idle_pct = 82;
        2:       idle_pct = 24;
        default: idle_pct = 0;
      endcase
      run_random(PhaseItems);
    end

    start_i <= 1'b0;
    while (bank.pending_reads.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("%0d commands issued in idle mixes of 0, 82 and 24 percent", cmds_sent);
    $display("%0d read beats checked, %0d mismatches", bank.reads_checked, bank.mismatches);
    if (bank.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
